>>> hw/rtl/supervisory_frame_receiver_unit_macros.svh
// Assertion macros shared by the supervisory frame receiver RTL.
// Depends on nothing; each user supplies clk and arst_n in its own scope.
`ifndef SUPERVISORY_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SUPERVISORY_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sfr_pkg.sv
// Shared types, constants and decode functions of the supervisory frame receiver.
// Used by the channel interfaces and the top level; depends on nothing.
package sfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int KIND_W   = 2;

	// Framing bytes.
	localparam logic [BYTE_W-1:0] FRAME_FLAG = 8'h7E;
	localparam logic [BYTE_W-1:0] FRAME_ADDR = 8'h03;

	// Control bytes.
	localparam logic [BYTE_W-1:0] CTL_UA   = 8'h07;
	localparam logic [BYTE_W-1:0] CTL_DISC = 8'h0B;
	localparam logic [BYTE_W-1:0] CTL_RR0  = 8'h05;
	localparam logic [BYTE_W-1:0] CTL_RR1  = 8'h85;
	localparam logic [BYTE_W-1:0] CTL_REJ0 = 8'h01;
	localparam logic [BYTE_W-1:0] CTL_REJ1 = 8'h81;

	// Awaited frame modes; the fourth code selects nothing.
	localparam logic [MODE_W-1:0] MODE_UA    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DISC  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REPLY = 2'd2;

	// Per-item status codes.
	localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	// Reply kinds.
	localparam logic [KIND_W-1:0] KIND_RR0  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RR1  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJ0 = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REJ1 = 2'd3;

	// Position within the frame: the byte expected next.
	typedef enum logic [2:0] {
		POS_FLAG_OPEN  = 3'd0,
		POS_ADDR       = 3'd1,
		POS_CTRL       = 3'd2,
		POS_CHECK      = 3'd3,
		POS_FLAG_CLOSE = 3'd4
	} pos_t;

	// True when the control byte suits the awaited frame.
	function automatic logic control_ok(input logic [MODE_W-1:0] mode,
			input logic [BYTE_W-1:0] c);
		logic ok;
		unique case (mode)
			MODE_UA:    ok = (c == CTL_UA);
			MODE_DISC:  ok = (c == CTL_DISC);
			MODE_REPLY: ok = (c == CTL_RR0) || (c == CTL_RR1) ||
				(c == CTL_REJ0) || (c == CTL_REJ1);
			default:    ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Reply kind of a control byte; anything else reads as zero.
	function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CTL_RR1:  k = KIND_RR1;
			CTL_REJ0: k = KIND_REJ0;
			CTL_REJ1: k = KIND_REJ1;
			default:  k = KIND_RR0;
		endcase
		return k;
	endfunction

endpackage

>>> hw/rtl/sfr_if.sv
// Valid/ready channel interfaces of the supervisory frame receiver.
// Depends on sfr_pkg for the payload widths.
interface sfr_byte_if;
	import sfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_status_if;
	import sfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] frame_status;
	logic [KIND_W-1:0]   reply_kind;

	modport source (output valid, output frame_status, output reply_kind, input ready);
	modport sink   (input valid, input frame_status, input reply_kind, output ready);
endinterface

>>> hw/rtl/supervisory_frame_receiver_unit.sv
// Supervisory frame receiver: checks link bytes against a five-byte frame.
// Depends on sfr_pkg, the interfaces in sfr_if.sv and the assertion macros header.
//
// Use: received bytes enter one item at a time on the rx channel (valid/ready,
// payload rx_byte). Each byte gives exactly one item on the status channel:
// frame_status (in progress, accepted, rejected) and reply_kind, which is
// non-zero only on an accepted reply frame. The awaited frame type is set by
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this. A byte taken on rx goes into the
// input register, then into the result register, where its status item waits
// to be taken. Throughput: one byte per cycle while the status receiver does
// not stall, set by the single compare-and-advance step between both registers.
// Reset (arst_n low) empties both registers, returns the receiver to waiting
// for an opening flag, clears the held control byte and selects UA frames.
// When the status receiver stalls, the result register holds its item, the
// input register still takes one more byte, and rx.ready then falls until
// the result is taken.
`include "supervisory_frame_receiver_unit_macros.svh"

module supervisory_frame_receiver_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sfr_pkg::MODE_W-1:0]  cfg_wdata,
	sfr_byte_if.sink                    rx,
	sfr_status_if.source                status
);
	import sfr_pkg::*;

	logic                s1_valid_q;
	logic [BYTE_W-1:0]   byte_s1;
	logic                s2_valid_q;
	logic [STATUS_W-1:0] status_s2;
	logic [KIND_W-1:0]   kind_s2;
	logic [MODE_W-1:0]   awaited_frame_q;
	logic [BYTE_W-1:0]   held_control_q;
	pos_t                pos_q;
	pos_t                pos_d;
	logic                byte_ok;
	logic                s2_free;
	logic                s2_load;
	logic                rx_take;
	logic [STATUS_W-1:0] res_status;
	logic [KIND_W-1:0]   res_kind;
	logic                acc_load;
	logic                rej_load;
	logic                kind_set;
	logic                s1_stall;

	// Handshake: the result register frees the input register.
	assign s2_free = !s2_valid_q || status.ready;
	assign s2_load = s1_valid_q && s2_free;
	assign rx.ready = !s1_valid_q || s2_free;
	assign rx_take = rx.valid && rx.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_frame_q <= MODE_UA;
		end else if (cfg_we) begin
			awaited_frame_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rx_take) begin
			s1_valid_q <= 1'b1;
		end else if (s2_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Next position: match the byte against the one expected here.
	always_comb begin
		byte_ok = 1'b0;
		pos_d   = POS_FLAG_OPEN;
		unique case (pos_q)
			POS_ADDR: begin
				byte_ok = (byte_s1 == FRAME_ADDR);
				pos_d   = POS_CTRL;
			end
			POS_CTRL: begin
				byte_ok = control_ok(awaited_frame_q, byte_s1);
				pos_d   = POS_CHECK;
			end
			POS_CHECK: begin
				byte_ok = (byte_s1 == (FRAME_ADDR ^ held_control_q));
				pos_d   = POS_FLAG_CLOSE;
			end
			POS_FLAG_CLOSE: begin
				byte_ok = (byte_s1 == FRAME_FLAG);
				pos_d   = POS_FLAG_OPEN;
			end
			default: begin
				byte_ok = (byte_s1 == FRAME_FLAG);
				pos_d   = POS_ADDR;
			end
		endcase
		if (!byte_ok) begin
			pos_d = POS_FLAG_OPEN;
		end
	end

	// Result of the current byte.
	always_comb begin
		res_kind = KIND_RR0;
		if (!byte_ok) begin
			res_status = ST_REJECT;
		end else if (pos_q == POS_FLAG_CLOSE) begin
			res_status = ST_ACCEPT;
			res_kind   = kind_of(held_control_q);
		end else begin
			res_status = ST_BUSY;
		end
	end

	// Frame state advances as each byte moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= POS_FLAG_OPEN;
			held_control_q <= '0;
		end else if (s2_load) begin
			pos_q <= pos_d;
			if (pos_q == POS_CTRL && byte_ok) begin
				held_control_q <= byte_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_load) begin
			s2_valid_q <= 1'b1;
		end else if (status.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			status_s2 <= res_status;
			kind_s2   <= res_kind;
		end
	end

	assign status.valid        = s2_valid_q;
	assign status.frame_status = status_s2;
	assign status.reply_kind   = kind_s2;

	// Conditions watched by the checks below.
	assign acc_load = s2_load && res_status == ST_ACCEPT;
	assign rej_load = s2_load && res_status == ST_REJECT;
	assign kind_set = s2_valid_q && kind_s2 != KIND_RR0;
	assign s1_stall = s1_valid_q && !s2_free;

	// Checks on the frame tracking.
	`SFR_ASSERT_NOW(a_accept_at_close, acc_load, pos_q == POS_FLAG_CLOSE, "early accept")
	`SFR_ASSERT_NEXT(a_reject_rearms, rej_load, pos_q == POS_FLAG_OPEN, "no rearm after reject")
	`SFR_ASSERT_NOW(a_kind_on_accept, kind_set, status_s2 == ST_ACCEPT, "kind without accept")
	`SFR_ASSERT_NEXT(a_input_held, s1_stall, s1_valid_q && $stable(byte_s1), "input lost")

endmodule
